// ----- src/alsa_pkg.sv -----
// Package for array_language_scan_alu: opcodes, fold modes, lane constants.
// No dependencies.
`default_nettype none
package alsa_pkg;

    localparam int LaneBits = 64;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 2;

    typedef enum logic [3:0] {
        OP_RIGHT = 4'd0,
        OP_ADD   = 4'd1,
        OP_SUB   = 4'd2,
        OP_MUL   = 4'd3,
        OP_DIV   = 4'd4,
        OP_MOD   = 4'd5,
        OP_MIN   = 4'd6,
        OP_MAX   = 4'd7,
        OP_LT    = 4'd8,
        OP_GT    = 4'd9,
        OP_EQ    = 4'd10
    } opcode_t;

    localparam logic [1:0] FOLD_ELEM  = 2'd0;
    localparam logic [1:0] FOLD_SCAN  = 2'd1;
    localparam logic [1:0] FOLD_PRIOR = 2'd2;

    localparam logic [CfgIdxW-1:0] REG_LANE_WIDTH = 1'd0;
    localparam logic [CfgIdxW-1:0] REG_FOLD_MODE  = 1'd1;

    // Sign-extend the low 32 bits when the lane is narrow.
    function automatic logic [63:0] lane_sext(input logic [63:0] v, input logic wide);
        lane_sext = wide ? v : {{32{v[31]}}, v[31:0]};
    endfunction

endpackage
`default_nettype wire

// ----- src/array_language_scan_alu.sv -----
// Top level of array_language_scan_alu: sequencer, shared ALU and divider.
// Depends on alsa_pkg and alsa_divider.
//
// Usage:
//  - s_axis carries one transaction per item: tdata = {right_operand,
//    left_operand, opcode} from bit 0 up (zero filled), tuser = restart.
//  - m_axis returns one transaction per item: tdata = result_value.
//  - cfg_we/cfg_idx/cfg_data write lane_width_mode (0) and fold_mode (1);
//    write only while the block is idle.
// Sequence per item:
//  - Simple ops: accept, compute, wrap to lane width, then the result
//    sits in the output register.
//  - Multiply: three 32x32 partial products through one shared multiplier,
//    one per cycle.
//  - Divide and modulo: accept, set-up, the iterative divider run, a step to
//    see done, then sign fix and output.
//  - One item is in flight at a time; s_axis_tready is low meanwhile.
// Reset: fold state and running value clear, lane_width_mode = 1 (64 bit).
// Stall: a held result keeps m_axis_tvalid high; no new item is taken until
// the result is accepted.
`default_nettype none
module array_language_scan_alu
    import alsa_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_axis_tvalid,
    output logic                     s_axis_tready,
    input  wire logic [135:0]        s_axis_tdata,  // opcode[3:0], left[67:4], right[131:68]
    input  wire logic                s_axis_tuser,  // restart
    output logic                     m_axis_tvalid,
    input  wire logic                m_axis_tready,
    output logic [63:0]              m_axis_tdata,  // result_value
    input  wire logic                cfg_we,
    input  wire logic [CfgIdxW-1:0]  cfg_idx,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_EXEC = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIX  = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t      state_reg, state_next;
    logic        wide_reg;
    logic [1:0]  fold_reg;
    logic [63:0] run_reg, run_next;
    logic [3:0]  op_reg, op_next;
    logic [63:0] x_reg, x_next;
    logic [63:0] y_reg, y_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  mstep_reg, mstep_next;
    logic [63:0] pp_reg;
    logic        div_start;
    logic [63:0] div_a, div_b;
    logic        div_done;
    logic [63:0] div_q, div_r;

    // inputs
    logic [3:0]  in_op;
    logic [63:0] in_x, in_y, fx, fy, run_ext;
    logic        in_restart;

    assign in_op      = s_axis_tdata[3:0];
    assign in_x       = lane_sext(s_axis_tdata[67:4], wide_reg);
    assign in_y       = lane_sext(s_axis_tdata[131:68], wide_reg);
    assign in_restart = s_axis_tuser;
    assign run_ext    = in_restart ? in_x : lane_sext(run_reg, wide_reg);

    always_comb
    begin
        priority if (fold_reg == FOLD_SCAN)
        begin
            fx = run_ext;
            fy = in_y;
        end
        else if (fold_reg == FOLD_PRIOR)
        begin
            fx = in_y;
            fy = run_ext;
        end
        else
        begin
            fx = in_x;
            fy = in_y;
        end
    end

    // shared multiplier: 32x32 partial products
    logic [31:0] ma, mb;
    always_comb
    begin
        unique case (mstep_reg)
            2'd0:    begin ma = x_reg[31:0];  mb = y_reg[31:0];  end
            2'd1:    begin ma = x_reg[63:32]; mb = y_reg[31:0];  end
            2'd2:    begin ma = x_reg[31:0];  mb = y_reg[63:32]; end
            default: begin ma = 32'd0;        mb = 32'd0;        end
        endcase
    end
    always_ff @(posedge clk)
        pp_reg <= ma * mb;

    // compares and simple ops
    logic        lt_xy, lt_yx;
    logic [63:0] simple;
    assign lt_xy = $signed(x_reg) < $signed(y_reg);
    assign lt_yx = $signed(y_reg) < $signed(x_reg);

    logic [63:0] nul;
    assign nul = wide_reg ? {1'b1, 63'd0} : {32'hFFFFFFFF, 1'b1, 31'd0};

    always_comb
    begin
        unique case (op_reg)
            OP_ADD:  simple = x_reg + y_reg;
            OP_SUB:  simple = x_reg - y_reg;
            OP_MIN:  simple = lt_yx ? y_reg : x_reg;
            OP_MAX:  simple = lt_xy ? y_reg : x_reg;
            OP_LT:   simple = {63'd0, lt_xy};
            OP_GT:   simple = {63'd0, lt_yx};
            OP_EQ:   simple = {63'd0, x_reg == y_reg};
            default: simple = y_reg;
        endcase
    end

    // divider set-up: div is x/y, mod is y/x
    logic        x_neg, y_neg, x_zero, y_zero;
    logic [63:0] x_mag, y_mag;
    assign x_neg  = x_reg[63];
    assign y_neg  = y_reg[63];
    assign x_zero = x_reg == 64'd0;
    assign y_zero = y_reg == 64'd0;
    assign x_mag  = x_neg ? -x_reg : x_reg;
    assign y_mag  = y_neg ? -y_reg : y_reg;
    // narrow-lane negative extreme modulus: -x wraps to x itself
    logic [63:0] mod_div;
    assign mod_div = (!wide_reg && x_reg == nul) ? {32'd0, 1'b1, 31'd0} : x_mag;

    always_comb
    begin
        if (op_reg == OP_DIV)
        begin
            div_a = x_mag;
            div_b = y_mag;
        end
        else
        begin
            div_a = y_mag;
            div_b = mod_div;
        end
    end

    // sign fix after division; mod with a negative modulus divides by -x > 0
    logic [63:0] q_s, r_s, fixres;
    assign q_s = ((op_reg == OP_DIV) ? (x_neg != y_neg) : y_neg) ? -div_q : div_q;
    assign r_s = y_neg ? -div_r : div_r;
    always_comb
    begin
        if (op_reg == OP_DIV)
            fixres = q_s;
        else if (!x_neg)
            fixres = r_s[63] ? r_s + x_reg : r_s;
        else if (!wide_reg && x_reg == nul)
            fixres = (y_reg == x_reg) ? 64'd1 : 64'd0;
        else if (wide_reg && x_reg == nul)
            fixres = (y_reg == x_reg) ? 64'd1 : 64'd0;
        else
            fixres = q_s;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        res_next   = res_reg;
        run_next   = run_reg;
        acc_next   = acc_reg;
        mstep_next = mstep_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = in_op;
                    x_next     = fx;
                    y_next     = fy;
                    mstep_next = 2'd0;
                    acc_next   = '0;
                    if (fold_reg == FOLD_PRIOR)
                        run_next = in_y;
                    else if (fold_reg == FOLD_SCAN && in_restart)
                        run_next = in_x;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_MUL)
                begin
                    mstep_next = 2'd1;
                    state_next = ST_MUL;
                end
                else if (op_reg == OP_DIV && y_zero)
                begin
                    res_next   = x_neg ? nul + 64'd1 : (x_zero ? nul : nul - 64'd1);
                    state_next = ST_FIX;
                end
                else if (op_reg == OP_MOD && x_zero)
                begin
                    res_next   = nul;
                    state_next = ST_FIX;
                end
                else if (op_reg == OP_DIV || op_reg == OP_MOD)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    res_next   = simple;
                    state_next = ST_FIX;
                end
            end
            ST_MUL:
            begin
                // pp_reg holds the product chosen by the previous step
                unique case (mstep_reg)
                    2'd1:    acc_next = pp_reg;
                    2'd2:    acc_next = acc_reg + {pp_reg[31:0], 32'd0};
                    default: acc_next = acc_reg + {pp_reg[31:0], 32'd0};
                endcase
                if (mstep_reg == 2'd3)
                begin
                    res_next   = acc_next;
                    state_next = ST_FIX;
                end
                else
                    mstep_next = mstep_reg + 2'd1;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    res_next   = fixres;
                    state_next = ST_FIX;
                end
            end
            ST_FIX:
            begin
                // wrap to lane width, update the scan accumulator
                res_next = lane_sext(res_reg, wide_reg);
                if (fold_reg == FOLD_SCAN)
                    run_next = res_next;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            wide_reg  <= 1'b1;
            fold_reg  <= FOLD_ELEM;
            run_reg   <= '0;
            mstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            run_reg   <= run_next;
            mstep_reg <= mstep_next;
            if (cfg_we && cfg_idx == REG_LANE_WIDTH)
                wide_reg <= cfg_data[0];
            if (cfg_we && cfg_idx == REG_FOLD_MODE)
                fold_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        res_reg <= res_next;
        acc_reg <= acc_next;
    end

    alsa_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    assign s_axis_tready = state_reg == ST_IDLE;
    assign m_axis_tvalid = state_reg == ST_OUT;
    assign m_axis_tdata  = res_reg;

endmodule
`default_nettype wire

// ----- src/alsa_divider.sv -----
// Iterative radix-2 unsigned divider, one quotient bit per cycle over 64 bits.
// Depends on alsa_pkg.
`default_nettype none
module alsa_divider
    import alsa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [63:0] divisor,
    output logic             done,
    output logic [63:0]      quotient,
    output logic [63:0]      remainder
);

    logic [63:0] quo_reg, quo_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] dvs_reg, dvs_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;
    logic [64:0] shifted;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[63]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[63:0];
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

// ----- bench/tb.sv -----
// Testbench for array_language_scan_alu: directed and random ALU transactions
// checked against an in-bench predictor. Depends on alsa_pkg and the RTL.
`timescale 1ns / 1ps
`default_nettype none

// Holds the configuration, the fold state and the queue of predicted results.
class alu_scoreboard;
    logic        wide;
    logic [1:0]  fold;
    logic [63:0] running;
    logic [63:0] pending_results[$];
    int          errors;

    function new();
        wide = 1'b1;
        fold = alsa_pkg::FOLD_ELEM;
        running = '0;
        errors = 0;
    endfunction

    function logic [63:0] lane(input logic [63:0] v);
        return wide ? v : {{32{v[31]}}, v[31:0]};
    endfunction

    function logic [63:0] magnitude(input logic [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function logic [63:0] trunc_div(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] q;
        q = magnitude(a) / magnitude(b);
        if (a[63] != b[63])
            q = -q;
        return lane(q);
    endfunction

    function logic [63:0] compute(input logic [3:0] op, input logic [63:0] x,
                                  input logic [63:0] y);
        logic [63:0] nul;
        logic [63:0] r;
        nul = wide ? 64'h8000_0000_0000_0000 : 64'hFFFF_FFFF_8000_0000;
        case (op)
            alsa_pkg::OP_ADD: return lane(x + y);
            alsa_pkg::OP_SUB: return lane(x - y);
            alsa_pkg::OP_MUL: return lane(x * y);
            alsa_pkg::OP_DIV:
            begin
                if (y == 0)
                begin
                    r = nul;
                    if (x[63])
                        r = r + 1;
                    else if (x != 0)
                        r = r - 1;
                    return lane(r);
                end
                return trunc_div(x, y);
            end
            alsa_pkg::OP_MOD:
            begin
                // positive modulus: floored; negative: truncating divide
                if (x != 0 && !x[63])
                begin
                    r = magnitude(y) % x;
                    if (y[63])
                        r = -r;
                    if (r[63])
                        r = r + x;
                    return lane(r);
                end
                if (x != 0)
                    return trunc_div(y, lane(-x));
                return nul;
            end
            alsa_pkg::OP_MIN: return ($signed(y) < $signed(x)) ? y : x;
            alsa_pkg::OP_MAX: return ($signed(x) < $signed(y)) ? y : x;
            alsa_pkg::OP_LT:  return ($signed(x) < $signed(y)) ? 64'd1 : 64'd0;
            alsa_pkg::OP_GT:  return ($signed(y) < $signed(x)) ? 64'd1 : 64'd0;
            alsa_pkg::OP_EQ:  return (x == y) ? 64'd1 : 64'd0;
            default:          return y;
        endcase
    endfunction

    function void note_item(input logic [3:0] op, input logic [63:0] l,
                            input logic [63:0] r, input logic restart);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] res;
        x = lane(l);
        y = lane(r);
        if (fold == alsa_pkg::FOLD_SCAN)
        begin
            if (restart)
                running = x;
            res = compute(op, lane(running), y);
            running = res;
        end
        else if (fold == alsa_pkg::FOLD_PRIOR)
        begin
            if (restart)
                running = x;
            res = compute(op, y, lane(running));
            running = y;
        end
        else
            res = compute(op, x, y);
        pending_results.push_back(res);
    endfunction

    function void check_result(input logic [63:0] got);
        logic [63:0] want;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
            return;
        end
        want = pending_results.pop_front();
        if (want !== got)
        begin
            $display("%0t: result_value mismatch, expected %h, actual %h",
                     $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb;
    import alsa_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // opcode[3:0], left[67:4], right[131:68]
    logic         s_axis_tuser;   // restart
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // result_value
    logic         cfg_we;
    logic [CfgIdxW-1:0]  cfg_idx;
    logic [CfgDataW-1:0] cfg_data;

    alu_scoreboard sb;
    int  cycle_count;
    bit  long_hold;

    array_language_scan_alu dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog: the worst case for ~1700 items plus stalls is well below this.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Result side: sample each accepted transaction, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    initial
    begin
        int hold;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold)
            begin
                // long hold-off while the sender keeps offering
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < 400; hold++)
                    @(posedge clk);
                long_hold = 0;
            end
            case (cycle_count[12:11])
                2'd0:    m_axis_tready <= 1'b1;
                2'd1:    m_axis_tready <= ($urandom_range(0, 3) != 0);
                default: m_axis_tready <= ($urandom_range(0, 1) != 0);
            endcase
        end
    end

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 7))
            0: return 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'(signed'($urandom_range(0, 20)) - 10);
            4: return {32'($urandom), 32'($urandom)} & 64'hFFFF_FFFF;
            5: return {1'b0, 32'h0, 31'($urandom)} ^ {64{$urandom_range(0, 1) == 1}};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // Offer one transaction and wait for acceptance.
    task automatic send_item(input logic [3:0] op, input logic [63:0] l,
                             input logic [63:0] r, input logic restart);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, r, l, op};
        s_axis_tuser  <= restart;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_item(op, l, r, restart);
    endtask

    task automatic idle_input(input int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Reconfigure only once all results are back, plus a short drain.
    task automatic write_config(input logic wide, input logic [1:0] fold);
        idle_input(1);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_LANE_WIDTH;
        cfg_data <= {1'b0, wide};
        @(posedge clk);
        cfg_idx  <= REG_FOLD_MODE;
        cfg_data <= fold;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.wide = wide;
        sb.fold = fold;
    endtask

    task automatic random_phase(input int n);
        int burst;
        int sent;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(1, 12);
            repeat (burst)
            begin
                // division heavy items are slow, keep them a minority
                send_item(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                              : 4'($urandom_range(0, 3) | ($urandom_range(0, 1) << 3)),
                          rand64(), rand64(), $urandom_range(0, 5) == 0);
                sent++;
            end
            if ($urandom_range(0, 2) == 0)
                idle_input(1);
            else
                idle_input($urandom_range(1, 6));
        end
        s_axis_tvalid <= 1'b0;
    endtask

    initial
    begin
        int op;
        sb = new();
        cycle_count = 0;
        long_hold = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every opcode at the extremes, div by zero, overflow,
        // extreme modulus, unused opcodes.
        for (op = 0; op < 16; op++)
            send_item(4'(op), 64'h8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_DIV, 64'd5, 64'd0, 1'b0);
        send_item(OP_DIV, -64'sd5, 64'd0, 1'b0);
        send_item(OP_DIV, 64'd0, 64'd0, 1'b0);
        send_item(OP_MOD, 64'd7, -64'sd9, 1'b0);
        send_item(OP_MOD, -64'sd4, 64'd9, 1'b0);
        send_item(OP_MOD, 64'd0, 64'd9, 1'b0);
        send_item(OP_MOD, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
        send_item(OP_MUL, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
        s_axis_tvalid <= 1'b0;

        // Back-pressure: receiver holds off while items keep coming.
        long_hold = 1;
        random_phase(30);

        write_config(1'b1, FOLD_SCAN);  random_phase(250);
        write_config(1'b0, FOLD_ELEM);  random_phase(250);
        send_item(OP_MOD, 64'hFFFF_FFFF_8000_0000, 64'h8000_0000, 1'b0);
        send_item(OP_DIV, 64'h8000_0000, 64'hFFFF_FFFF, 1'b0);
        s_axis_tvalid <= 1'b0;
        write_config(1'b0, FOLD_SCAN);  random_phase(250);
        write_config(1'b0, FOLD_PRIOR); random_phase(250);
        write_config(1'b1, FOLD_PRIOR); random_phase(250);
        write_config(1'b1, 2'd3);       random_phase(200);
        write_config(1'b1, FOLD_ELEM);  random_phase(150);

        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

`default_nettype wire
